// File: rtl/ffea_pkg.sv
`default_nettype none
package ffea_pkg;
    typedef enum logic [1:0] {OP_ALLOC = 2'd0, OP_FREE = 2'd1, OP_FORMAT = 2'd2, OP_NONE = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_ZERO = 2'd1, ST_OOM = 2'd2, ST_FULL = 2'd3} status_t;
    typedef enum logic [0:0] {CFG_REGION_START = 1'b0, CFG_REGION_END = 1'b1} cfg_idx_t;

    // controller commands to datapath
    typedef struct packed {
        logic load;       // capture request
        logic rd;         // read the entry after the scan index
        logic scan_adv;   // advance scan index
        logic shift_step; // move one entry (direction from shift_up)
        logic shift_up;   // 1: open a hole, 0: close a hole
        logic open_start; // remember slot, jump index to count
        logic wr_front;   // write carved / merged entry
        logic fmt;        // format write
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic set_prev;   // remember last read entry as previous
    } cmd_t;

    typedef struct packed {
        logic zero;       // rounded size empty
        logic at_end;     // scan index reached count
        logic fit;        // read entry large enough
        logic exact;      // exact fit
        logic past;       // read entry offset >= free offset
        logic prev_adj;
        logic next_adj;
        logic full;
        logic shift_done; // no later entry left to pull down
        logic at_slot;    // opening walk reached the slot
        logic fmt_empty;
    } sts_t;
endpackage
`default_nettype wire

// File: rtl/ffea_ram.sv
`default_nettype none
module ffea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/ffea_datapath.sv
`default_nettype none
module ffea_datapath #(
    parameter int MAX_EXTENTS = 64,
    parameter int ALIGN_BYTES = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ffea_pkg::cmd_t                 cmd,
    output ffea_pkg::sts_t                      sts,
    input  wire logic [1:0]                     op,
    input  wire logic [31:0]                    req_size,
    input  wire logic [31:0]                    free_offset,
    input  wire logic [31:0]                    region_start,
    input  wire logic [31:0]                    region_end,
    output logic [31:0]                         found_offset,
    output logic [$clog2(MAX_EXTENTS+1)-1:0]    count
);
    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS+1);
    localparam int SW = 33;

    logic [SW-1:0] size_reg, size_next;
    logic [31:0]   foff_reg;
    logic [1:0]    op_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] slot_reg;
    logic [31:0]   poff_reg, plen_reg;
    logic          have_prev_reg;
    logic [63:0]   rdata;
    logic [AW-1:0] raddr, waddr;
    logic [63:0]   wdata;
    logic          we;
    logic [31:0]   r_off, r_len;
    logic [SW:0]   rounded;
    logic [SW:0]   fend;

    assign r_off = rdata[63:32];
    assign r_len = rdata[31:0];

    // round to alignment; ALIGN_BYTES is a constant
    always_comb
    begin
        rounded = ({2'b00, req_size} + (SW+1)'(ALIGN_BYTES - 1)) / (SW+1)'(ALIGN_BYTES);
        rounded = rounded * (SW+1)'(ALIGN_BYTES);
        size_next = rounded[SW-1:0];
        // clip a free at the top of the offset range
        fend = {2'b00, free_offset} + rounded;
        if (op == ffea_pkg::OP_FREE && fend > (SW+1)'(34'h0FFFFFFFF))
        begin
            size_next = SW'(33'h0FFFFFFFF - {1'b0, free_offset});
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.open_start)
        begin
            idx_next = cnt_reg;
        end
        else if (cmd.scan_adv)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.shift_step && cmd.shift_up)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.shift_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            // format clears and may install its one extent together
            cnt_next = {{(CW-1){1'b0}}, cmd.cnt_inc};
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                have_prev_reg <= 1'b0;
            end
            else if (cmd.set_prev)
            begin
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= size_next;
            foff_reg <= free_offset;
            op_reg <= op;
        end
        if (cmd.set_prev)
        begin
            poff_reg <= r_off;
            plen_reg <= r_len;
        end
        if (cmd.open_start)
        begin
            slot_reg <= idx_reg;
        end
    end

    // memory addressing: reads at idx-2..idx+2, set by the command
    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        waddr = idx_reg[AW-1:0];
        wdata = rdata;
        we = 1'b0;
        if (cmd.shift_step && cmd.shift_up)
        begin
            raddr = AW'(idx_reg - 2'd2);
            we = 1'b1; // write rdata (entry idx-1) into idx
        end
        else if (cmd.shift_step)
        begin
            raddr = AW'(idx_reg + 2'd2);
            we = 1'b1; // write rdata (entry idx+1) into idx
        end
        else if (cmd.shift_up)
        begin
            raddr = AW'(idx_reg - 1'b1);
        end
        else if (cmd.rd)
        begin
            raddr = AW'(idx_reg + 1'b1);
        end
        else if (cmd.wr_front)
        begin
            raddr = AW'(idx_reg + 1'b1);
        end
        if (cmd.fmt)
        begin
            we = 1'b1;
            waddr = '0;
            wdata = {region_start, region_end - region_start};
        end
        else if (cmd.wr_front)
        begin
            we = 1'b1;
            case (op_reg)
                ffea_pkg::OP_ALLOC:
                begin
                    wdata = {r_off + size_reg[31:0], r_len - size_reg[31:0]};
                end
                default:
                begin
                    // free write: idx names target slot
                    if (sts.prev_adj && sts.next_adj)
                    begin
                        waddr = AW'(idx_reg - 1'b1);
                        wdata = {poff_reg, plen_reg + size_reg[31:0] + r_len};
                    end
                    else if (sts.next_adj)
                    begin
                        wdata = {foff_reg, r_len + size_reg[31:0]};
                    end
                    else if (sts.prev_adj)
                    begin
                        waddr = AW'(idx_reg - 1'b1);
                        wdata = {poff_reg, plen_reg + size_reg[31:0]};
                    end
                    else
                    begin
                        wdata = {foff_reg, size_reg[31:0]};
                    end
                end
            endcase
        end
    end

    ffea_ram #(.WIDTH(64), .DEPTH(MAX_EXTENTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.zero       = (size_reg == '0);
        sts.at_end     = (idx_reg >= cnt_reg);
        sts.fit        = ({1'b0, r_len} >= size_reg);
        sts.exact      = ({1'b0, r_len} == size_reg);
        sts.past       = (r_off >= foff_reg);
        sts.prev_adj   = have_prev_reg && ({1'b0, poff_reg} + {1'b0, plen_reg} == {1'b0, foff_reg});
        sts.next_adj   = !sts.at_end && ({1'b0, foff_reg} + size_reg == {1'b0, r_off});
        sts.full       = (cnt_reg >= CW'(MAX_EXTENTS));
        sts.shift_done = (idx_reg + 1'b1 >= cnt_reg);
        sts.at_slot    = (idx_reg == slot_reg);
        sts.fmt_empty  = !(region_end > region_start);
    end

    assign found_offset = r_off;
    assign count = cnt_reg;
endmodule
`default_nettype wire

// File: rtl/ffea_ctrl.sv
`default_nettype none
module ffea_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [1:0]      op,
    input  wire logic [31:0]     req_size,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [1:0]           status_reg_o,
    output logic                 off_we,
    output ffea_pkg::cmd_t       cmd,
    input  wire ffea_pkg::sts_t  sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD, S_CHK, S_WR, S_CLOSE, S_OPEN, S_WR_UP, S_INS, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] op_reg;
    logic [1:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    logic       zreq_reg;

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        off_we = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next = ffea_pkg::ST_OK;
                state_next = S_DONE;
                case (op_reg)
                    ffea_pkg::OP_ALLOC, ffea_pkg::OP_FREE:
                    begin
                        if (zreq_reg || sts.zero)
                        begin
                            st_next = ffea_pkg::ST_ZERO;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    ffea_pkg::OP_FORMAT:
                    begin
                        cmd.cnt_clr = 1'b1;
                        if (!sts.fmt_empty)
                        begin
                            cmd.fmt = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (op_reg == ffea_pkg::OP_ALLOC)
                begin
                    if (sts.at_end)
                    begin
                        st_next = ffea_pkg::ST_OOM;
                        state_next = S_DONE;
                    end
                    else if (sts.fit)
                    begin
                        off_we = 1'b1;
                        st_next = ffea_pkg::ST_OK;
                        if (sts.exact)
                        begin
                            cmd.shift_up = 1'b0;
                            state_next = S_CLOSE;
                        end
                        else
                        begin
                            cmd.wr_front = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (sts.at_end || sts.past)
                    begin
                        st_next = ffea_pkg::ST_OK;
                        if (sts.prev_adj && sts.next_adj)
                        begin
                            cmd.wr_front = 1'b1;
                            state_next = S_CLOSE;
                        end
                        else if (sts.next_adj || sts.prev_adj)
                        begin
                            cmd.wr_front = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (sts.full)
                        begin
                            st_next = ffea_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.open_start = 1'b1;
                            state_next = S_OPEN;
                        end
                    end
                    else
                    begin
                        cmd.set_prev = 1'b1;
                        cmd.scan_adv = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_CLOSE:
            begin
                // idx is the hole; pull entries down one a step
                if (sts.shift_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.shift_step = 1'b1;
                state_next = S_CLOSE;
            end
            S_OPEN:
            begin
                // idx walks from count down to the slot
                if (sts.at_slot)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    cmd.shift_up = 1'b1;
                    state_next = S_WR_UP;
                end
            end
            S_WR_UP:
            begin
                cmd.shift_step = 1'b1;
                cmd.shift_up = 1'b1;
                state_next = S_OPEN;
            end
            S_INS:
            begin
                cmd.wr_front = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg <= ffea_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            op_reg <= ffea_pkg::OP_ALLOC;
            zreq_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg <= st_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                op_reg <= op;
                zreq_reg <= (req_size == 32'd0);
            end
        end
    end

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status_reg_o = st_reg;
endmodule
`default_nettype wire

// File: rtl/first_fit_extent_allocator_unit.sv
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | op, req_size, free_offset
// out     | output    | out_valid/stall  | status, alloc_offset, extent_count
// cfg     | input     | cfg_valid/ready  | cfg_index, cfg_data
// One item at a time. An allocate scans the extent table one entry at a time,
// a read state then a check state per entry, and closes a hole by moving each
// later entry down (a read, then a write); a free scans to its slot and may
// open or close a hole the same way. The table memory has one read port, one
// write port and a registered read.
// Reset clears the extent count and control; table contents need no clearing.
// The input stalls while an item is in progress and until its result is taken.
`default_nettype none
module first_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = 64,
    parameter int ALIGN_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] req_size,
    input  wire logic [31:0] free_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      alloc_offset,
    output logic [6:0]       extent_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int CW = $clog2(MAX_EXTENTS+1);

    ffea_pkg::cmd_t cmd;
    ffea_pkg::sts_t sts;
    logic [31:0] rs_reg, re_reg, aoff_reg;
    logic [31:0] found;
    logic [CW-1:0] cnt;
    logic off_we;
    logic [1:0] st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= '0;
            re_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ffea_pkg::CFG_REGION_START)
            begin
                rs_reg <= cfg_data;
            end
            else
            begin
                re_reg <= cfg_data;
            end
        end
    end
    assign cfg_ready = 1'b1;

    ffea_datapath #(.MAX_EXTENTS(MAX_EXTENTS), .ALIGN_BYTES(ALIGN_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .op(op),
        .req_size(req_size), .free_offset(free_offset),
        .region_start(rs_reg), .region_end(re_reg),
        .found_offset(found), .count(cnt)
    );

    ffea_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .req_size(req_size), .out_valid(out_valid), .out_stall(out_stall),
        .status_reg_o(st), .off_we(off_we), .cmd(cmd), .sts(sts)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            aoff_reg <= '0;
        end
        else if (off_we)
        begin
            aoff_reg <= found;
        end
    end

    assign status = st;
    assign alloc_offset = (st == ffea_pkg::ST_OK) ? aoff_reg : 32'd0;
    assign extent_count = 7'(cnt);
endmodule
`default_nettype wire

// File: rtl/ffea_checker.sv
`default_nettype none
module ffea_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [31:0] alloc_offset
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(alloc_offset))
        else $error("stalled result changed");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result held");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("input open while busy");
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffea_pkg::ST_OK |-> alloc_offset == 32'd0)
        else $error("offset on failure");
endmodule
bind first_fit_extent_allocator_unit ffea_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .alloc_offset(alloc_offset)
);
`default_nettype wire
